/* design/cftc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the telemetry frame checker.
package cftc_pkg;

    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [7:0]  MIN_FRAME_BYTES = 8'd3;
    localparam logic [7:0]  ATT_MIN_BYTES   = 8'd16;
    localparam logic [7:0]  ATT_FIRST_POS   = 8'd2;
    localparam logic [7:0]  ATT_LAST_POS    = 8'd13;
    localparam logic [7:0]  COUNT_MAX       = 8'd255;
    localparam int unsigned ATT_BYTES       = 12;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LEN  = 2'd1,
        ST_CRC  = 2'd2,
        ST_SIZE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_datagram;
    } t_req;

    typedef struct packed {
        logic        frame_ok;
        t_status     status;
        logic [7:0]  message_type;
        logic        attitude_valid;
        logic [31:0] roll_bits;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_bits;
        logic [7:0]  frame_length;
    } t_result;

    // CRC-16/XMODEM, MSB first, one byte per call.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/cftc_frame.sv */
// Frame state, CRC and length checks, and the result register.
module cftc_frame #(
    parameter int unsigned MAX_FRAME_BYTES = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cftc_pkg::t_req    i_req,
    input  logic              i_out_stall,
    output logic              o_valid,
    output cftc_pkg::t_result o_result
);
    import cftc_pkg::*;

    localparam logic [7:0] MAX_BYTES = 8'(MAX_FRAME_BYTES);

    logic [15:0] r_crc;
    logic [7:0]  r_count;
    logic [7:0]  r_held0;
    logic [7:0]  r_held1;
    logic [7:0]  r_declared;
    logic [7:0]  r_type;
    logic [7:0]  r_att [ATT_BYTES];
    logic        r_out_valid;
    t_result     r_result;

    logic [15:0] n_crc;
    logic [7:0]  n_count;
    logic [7:0]  n_declared;
    logic [7:0]  n_type;
    logic [3:0]  att_idx;
    logic        att_wr;
    logic [15:0] rx_crc;
    t_status     status;
    logic        att_ok;
    t_result     n_result;

    always_comb begin
        n_crc      = (r_count >= 8'd2) ? crc_feed(r_crc, r_held0) : r_crc;
        n_count    = (r_count == COUNT_MAX) ? r_count : r_count + 8'd1;
        n_declared = (r_count == 8'd0) ? i_req.rx_byte : r_declared;
        n_type     = (r_count == 8'd1) ? i_req.rx_byte : r_type;
        att_wr     = (r_count >= ATT_FIRST_POS) && (r_count <= ATT_LAST_POS);
        att_idx    = r_count[3:0] - 4'd2;
        // The trailer is the two newest bytes once this one is shifted in.
        rx_crc     = {r_held1, i_req.rx_byte};

        if ((n_count < MIN_FRAME_BYTES) || (n_count > MAX_BYTES)) begin
            status = ST_SIZE;
        end else if (n_declared != n_count) begin
            status = ST_LEN;
        end else if (rx_crc != n_crc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end

        // Attitude needs at least sixteen bytes, so all twelve are already held.
        att_ok = (status == ST_OK) && (n_type == 8'd0) && (n_count >= ATT_MIN_BYTES);

        n_result.frame_ok       = (status == ST_OK);
        n_result.status         = status;
        n_result.message_type   = n_type;
        n_result.attitude_valid = att_ok;
        n_result.roll_bits      = att_ok ? {r_att[3], r_att[2], r_att[1], r_att[0]} : 32'd0;
        n_result.pitch_bits     = att_ok ? {r_att[7], r_att[6], r_att[5], r_att[4]} : 32'd0;
        n_result.yaw_bits       = att_ok ? {r_att[11], r_att[10], r_att[9], r_att[8]} : 32'd0;
        n_result.frame_length   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= 16'd0;
            r_count    <= 8'd0;
            r_held0    <= 8'd0;
            r_held1    <= 8'd0;
            r_declared <= 8'd0;
            r_type     <= 8'd0;
        end else if (i_fire) begin
            if (i_req.end_of_datagram) begin
                r_crc      <= 16'd0;
                r_count    <= 8'd0;
                r_held0    <= 8'd0;
                r_held1    <= 8'd0;
                r_declared <= 8'd0;
                r_type     <= 8'd0;
            end else begin
                r_crc      <= n_crc;
                r_count    <= n_count;
                r_held0    <= r_held1;
                r_held1    <= i_req.rx_byte;
                r_declared <= n_declared;
                r_type     <= n_type;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && att_wr) begin
            r_att[att_idx] <= i_req.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_fire && i_req.end_of_datagram) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_req.end_of_datagram) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

/* design/crc16_framed_telemetry_checker.sv */
// Top level of the CRC-16 framed telemetry checker: input register and handshake.
//
// Bytes of a datagram enter on the input channel (i_rx_byte, with
// i_end_of_datagram high on the final byte). Each accepted byte is held in an
// input register and then folded into the frame state: the running
// CRC-16/XMODEM, byte count, length and type bytes, and the attitude words.
// Only the final byte of a datagram produces a request on the output
// channel; the other bytes produce nothing.
// Throughput is one byte per cycle while o_stall is low, set by the single
// byte-wide CRC update between the input register and the result register.
// A result is registered when its final byte leaves the input register.
// When the receiver stalls, the held result stays put and the block keeps
// taking bytes of the next datagram; only when that datagram's final byte
// reaches the input register while a result still waits does i_stall back up
// to o_stall. After reset both channels are empty and the frame state is
// clear, so the first byte accepted is byte 0 of a new frame.
module crc16_framed_telemetry_checker #(
    parameter int unsigned MAX_FRAME_BYTES = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_datagram,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_ok,
    output logic [1:0]  o_status,
    output logic [7:0]  o_message_type,
    output logic        o_attitude_valid,
    output logic [31:0] o_roll_bits,
    output logic [31:0] o_pitch_bits,
    output logic [31:0] o_yaw_bits,
    output logic [7:0]  o_frame_length
);
    import cftc_pkg::*;

    logic    r_in_valid;
    t_req    r_in;
    logic    advance;
    logic    fire;
    logic    out_valid;
    t_result result;

    // A byte that yields no result can always move on.
    assign advance = !r_in_valid || !r_in.end_of_datagram || !out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && advance) begin
            r_in.rx_byte         <= i_rx_byte;
            r_in.end_of_datagram <= i_end_of_datagram;
        end
    end

    cftc_frame #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (r_in),
        .i_out_stall (i_stall),
        .o_valid     (out_valid),
        .o_result    (result)
    );

    assign o_valid          = out_valid;
    assign o_frame_ok       = result.frame_ok;
    assign o_status         = result.status;
    assign o_message_type   = result.message_type;
    assign o_attitude_valid = result.attitude_valid;
    assign o_roll_bits      = result.roll_bits;
    assign o_pitch_bits     = result.pitch_bits;
    assign o_yaw_bits       = result.yaw_bits;
    assign o_frame_length   = result.frame_length;

endmodule

/* design/cftc_checker.sv */
// Port-level assertions for the telemetry frame checker, bound to the top level.
module cftc_checker #(
    parameter int unsigned MAX_FRAME_BYTES = 20
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        o_frame_ok,
    input logic [1:0]  o_status,
    input logic [7:0]  o_message_type,
    input logic        o_attitude_valid,
    input logic [31:0] o_roll_bits,
    input logic [31:0] o_pitch_bits,
    input logic [31:0] o_yaw_bits,
    input logic [7:0]  o_frame_length
);
    import cftc_pkg::*;

    localparam logic [7:0] MAX_BYTES = 8'(MAX_FRAME_BYTES);

    a_ok_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_ok == (o_status == ST_OK)))
        else $error("frame_ok disagrees with status");

    a_attitude_rules: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_attitude_valid) |->
            (o_frame_ok && (o_message_type == 8'd0) && (o_frame_length >= ATT_MIN_BYTES)))
        else $error("attitude flagged on an unsuitable frame");

    a_attitude_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_attitude_valid) |->
            ((o_roll_bits == 32'd0) && (o_pitch_bits == 32'd0) && (o_yaw_bits == 32'd0)))
        else $error("attitude words not cleared");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_SIZE)) |->
            ((o_frame_length >= MIN_FRAME_BYTES) && (o_frame_length <= MAX_BYTES)))
        else $error("size fault not reported");

endmodule

bind crc16_framed_telemetry_checker cftc_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
) u_cftc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .o_frame_ok       (o_frame_ok),
    .o_status         (o_status),
    .o_message_type   (o_message_type),
    .o_attitude_valid (o_attitude_valid),
    .o_roll_bits      (o_roll_bits),
    .o_pitch_bits     (o_pitch_bits),
    .o_yaw_bits       (o_yaw_bits),
    .o_frame_length   (o_frame_length)
);

/* tb/crc16_framed_telemetry_checker_test.sv */
// Self-checking testbench for the CRC-16 framed telemetry checker.
module crc16_framed_telemetry_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cftc_pkg::*;

    localparam int MAX_LEN     = 20;
    localparam int HOLD_CYCLES = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_end_of_datagram = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_frame_ok;
    logic [1:0]  o_status;
    logic [7:0]  o_message_type;
    logic        o_attitude_valid;
    logic [31:0] o_roll_bits;
    logic [31:0] o_pitch_bits;
    logic [31:0] o_yaw_bits;
    logic [7:0]  o_frame_length;

    // Idling rates in percent, and the long receiver hold-off requested by the tests.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;

    int fault_count = 0;
    int sent_bytes = 0;

    // Predicted frame state, mirroring what the block tracks between final bytes.
    logic [15:0] fr_crc = 16'h0000;
    logic [7:0]  fr_count = 8'h00;
    logic [7:0]  fr_delay [2] = '{8'h00, 8'h00};
    logic [7:0]  fr_len_byte = 8'h00;
    logic [7:0]  fr_type = 8'h00;
    logic [31:0] fr_att [3] = '{32'h0, 32'h0, 32'h0};

    t_result     expected_reports [$];
    logic [7:0]  frame_bytes [$];

    crc16_framed_telemetry_checker #(
        .MAX_FRAME_BYTES(MAX_LEN)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_ok        (o_frame_ok),
        .o_status          (o_status),
        .o_message_type    (o_message_type),
        .o_attitude_valid  (o_attitude_valid),
        .o_roll_bits       (o_roll_bits),
        .o_pitch_bits      (o_pitch_bits),
        .o_yaw_bits        (o_yaw_bits),
        .o_frame_length    (o_frame_length)
    );

    always #5 i_clk = ~i_clk;

    // Bitwise CRC-16/XMODEM update, most significant bit first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Folds one accepted byte into the predicted frame state and, on the final
    // byte, queues the report the block should give.
    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        logic [15:0] trailer;
        t_status     st;
        logic        att;
        t_result     rep;
        int          off;
        if (fr_count >= 2) begin
            fr_crc = crc16_step(fr_crc, fr_delay[0]);
        end
        fr_delay[0] = fr_delay[1];
        fr_delay[1] = b;
        if (fr_count == 0) begin
            fr_len_byte = b;
        end else if (fr_count == 1) begin
            fr_type = b;
        end else if (fr_count <= ATT_LAST_POS) begin
            off = int'(fr_count - ATT_FIRST_POS);
            fr_att[off / 4][8 * (off % 4) +: 8] = b;
        end
        if (fr_count != COUNT_MAX) begin
            fr_count++;
        end
        if (last) begin
            trailer = {fr_delay[0], fr_delay[1]};
            if (fr_count < MIN_FRAME_BYTES || fr_count > MAX_LEN) begin
                st = ST_SIZE;
            end else if (fr_len_byte != fr_count) begin
                st = ST_LEN;
            end else if (trailer != fr_crc) begin
                st = ST_CRC;
            end else begin
                st = ST_OK;
            end
            att = (st == ST_OK) && (fr_type == 8'h00) && (fr_count >= ATT_MIN_BYTES);
            rep.frame_ok       = (st == ST_OK);
            rep.status         = st;
            rep.message_type   = fr_type;
            rep.attitude_valid = att;
            rep.roll_bits      = att ? fr_att[0] : 32'h0;
            rep.pitch_bits     = att ? fr_att[1] : 32'h0;
            rep.yaw_bits       = att ? fr_att[2] : 32'h0;
            rep.frame_length   = fr_count;
            expected_reports.push_back(rep);
            // Each datagram starts from a clear frame state.
            fr_crc      = 16'h0000;
            fr_count    = 8'h00;
            fr_delay[0] = 8'h00;
            fr_delay[1] = 8'h00;
            fr_len_byte = 8'h00;
            fr_type     = 8'h00;
            fr_att[0]   = 32'h0;
            fr_att[1]   = 32'h0;
            fr_att[2]   = 32'h0;
        end
    endtask

    // Offers one byte and returns at the edge where the request is taken.
    // Valid is left high so that the next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_rx_byte         <= b;
        i_end_of_datagram <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sent_bytes++;
        track_frame_byte(b, last);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // Random bytes with the length and type bytes in place; no CRC trailer yet.
    task automatic fill_frame(input int len, input logic [7:0] len_byte, input logic [7:0] msg);
        frame_bytes.delete();
        for (int i = 0; i < len; i++) begin
            frame_bytes.push_back(8'($urandom));
        end
        frame_bytes[0] = len_byte;
        if (len > 1) begin
            frame_bytes[1] = msg;
        end
    endtask

    // Writes the big-endian CRC over every byte before the trailer, spoilt by flip.
    task automatic seal_frame(input logic [15:0] flip);
        logic [15:0] crc;
        int          len;
        len = frame_bytes.size();
        crc = 16'h0000;
        for (int i = 0; i < len - 2; i++) begin
            crc = crc16_step(crc, frame_bytes[i]);
        end
        crc = crc ^ flip;
        frame_bytes[len - 2] = crc[15:8];
        frame_bytes[len - 1] = crc[7:0];
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic test_directed();
        logic [95:0] pay;
        // A lone byte: size fault, and no type byte was ever seen.
        fill_frame(1, 8'hFF, 8'h00);
        send_frame();
        fill_frame(2, 8'h02, 8'hA5);
        send_frame();
        // Good attitude frame with all-zero and all-one payload bytes.
        pay = {32'h80000000, 32'hFFFFFFFF, 32'h3F800000};
        fill_frame(16, 8'd16, 8'h00);
        for (int i = 0; i < ATT_BYTES; i++) begin
            frame_bytes[ATT_FIRST_POS + i] = pay[8 * i +: 8];
        end
        seal_frame(16'h0000);
        send_frame();
        // A wrong length byte outranks a bad CRC.
        fill_frame(3, 8'd5, 8'h00);
        seal_frame(16'h0001);
        send_frame();
        fill_frame(3, 8'd3, 8'h00);
        seal_frame(16'h8000);
        send_frame();
    endtask

    task automatic test_random(input int byte_budget);
        int         start;
        int         len;
        int         pick;
        logic [7:0] msg;
        start = sent_bytes;
        while (sent_bytes - start < byte_budget) begin
            pick = $urandom_range(99);
            msg  = $urandom_range(1) ? 8'h00 : 8'($urandom);
            if (pick < 60) begin
                len = $urandom_range(MAX_LEN, 3);
                fill_frame(len, 8'(len), msg);
                seal_frame(16'h0000);
            end else if (pick < 70) begin
                len = $urandom_range(MAX_LEN, ATT_MIN_BYTES);
                fill_frame(len, 8'(len), 8'h00);
                seal_frame(16'h0000);
            end else if (pick < 80) begin
                len = $urandom_range(MAX_LEN, 3);
                fill_frame(len, 8'(len + $urandom_range(255, 1)), msg);
                seal_frame(16'h0000);
            end else if (pick < 90) begin
                len = $urandom_range(MAX_LEN, 3);
                fill_frame(len, 8'(len), msg);
                seal_frame(16'($urandom_range(16'hFFFF, 1)));
            end else begin
                // Noise: any size, possibly oversized, length byte and CRC left to chance.
                len = $urandom_range(40, 1);
                fill_frame(len, $urandom_range(1) ? 8'(len) : 8'($urandom), msg);
                if (len >= 3 && $urandom_range(1)) begin
                    seal_frame(16'h0000);
                end
            end
            send_frame();
        end
    endtask

    // A frame long enough for the byte count to saturate.
    task automatic test_long_frame();
        fill_frame($urandom_range(270, 256), 8'($urandom), 8'h00);
        seal_frame(16'h0000);
        send_frame();
    endtask

    // The receiver holds off while short frames keep coming, so the block
    // fills up and has to stall its input.
    task automatic test_backpressure();
        int len;
        set_idling(0, 0);
        hold_ticket <= hold_ticket + 1;
        repeat (6) begin
            len = $urandom_range(6, 3);
            fill_frame(len, 8'(len), 8'($urandom));
            seal_frame(16'h0000);
            send_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES - 1;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("%0t: result request with no frame pending", $realtime);
                end
            end else begin
                want = expected_reports.pop_front();
                check_field("frame_ok", 32'(want.frame_ok), 32'(o_frame_ok));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("message_type", 32'(want.message_type), 32'(o_message_type));
                check_field("attitude_valid", 32'(want.attitude_valid),
                            32'(o_attitude_valid));
                check_field("roll_bits", want.roll_bits, o_roll_bits);
                check_field("pitch_bits", want.pitch_bits, o_pitch_bits);
                check_field("yaw_bits", want.yaw_bits, o_yaw_bits);
                check_field("frame_length", 32'(want.frame_length), 32'(o_frame_length));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("crc16_framed_telemetry_checker_test: FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(32, 49);
        test_directed();
        test_random(70);
        set_idling(49, 32);
        test_random(70);
        set_idling(0, 0);
        test_long_frame();
        test_random(70);
        test_backpressure();

        i_valid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("crc16_framed_telemetry_checker_test: PASS");
        end else begin
            $display("crc16_framed_telemetry_checker_test: FAIL");
        end
        $finish;
    end

endmodule
